>>> hw/rtl/mbhr_pkg.sv
package mbhr_pkg;

   localparam logic [7:0] FN_READ       = 8'h03;
   localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
   localparam logic [7:0] FN_WRITE_MANY = 8'h10;

   localparam int unsigned HDR_KEEP   = 13;
   localparam int unsigned MBAP_BYTES = 6;
   localparam int unsigned MIN_FRAME  = 12;
   localparam int unsigned MIN_MANY   = 13;
   localparam int unsigned DATA_AT    = 9;
   localparam int unsigned ECHO_LAST  = 11;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RX,
      ST_WR_HI,
      ST_WR_LO,
      ST_EMIT,
      ST_FETCH
   } state_type;

   typedef enum logic [1:0] {
      KIND_READ,
      KIND_WRITE_ONE,
      KIND_WRITE_MANY
   } kind_type;

endpackage

>>> hw/rtl/mbhr_if.sv
interface mbhr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbhr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last;
   modport source (output valid, output tx_byte, output last, input ready);
   modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

>>> hw/rtl/mbhr_ram.sv
module mbhr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/modbus_tcp_holding_register_slave.sv
// Modbus TCP holding-register server. Request bytes enter one per cycle on req_bus and are framed
// by the MBAP length (frame = length + 6 bytes); functions 0x03, 0x06 and 0x10 act on a
// byte-wide register store of REG_BYTES bytes held in a single RAM, and invalid frames are
// consumed without a response. While a frame is arriving a byte is taken every cycle, with 0x10
// data written as it arrives. After the last byte of a frame that answers, the block stops taking
// bytes while it sends the response: echoed bytes are loaded straight into the output register and
// each read data byte takes a RAM read and then a load, and 0x06 first makes two writes on the single
// RAM write port before its 12-byte echo. After reset a clearing pass writes zero to every byte of
// the store in turn, and no byte is taken until it ends.
module modbus_tcp_holding_register_slave #(
   parameter int unsigned REG_BYTES     = 256,
   parameter int unsigned MAX_READ_REGS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mbhr_req_if.sink   req_bus,
   mbhr_rsp_if.source rsp_bus
);
   localparam int unsigned AW = $clog2(REG_BYTES);
   localparam int unsigned KW = $clog2(mbhr_pkg::DATA_AT + 2 * MAX_READ_REGS + 1);
   localparam logic [17:0] RB = 18'(REG_BYTES);

   mbhr_pkg::state_type state_ff, state_in;
   mbhr_pkg::kind_type  kind_ff, kind_in;
   logic [16:0]   pos_ff, pos_in;
   logic [16:0]   total_ff, total_in;
   logic          rej_ff, rej_in;
   logic [7:0]    hdr_ff [mbhr_pkg::HDR_KEEP];
   logic [7:0]    hdr_nx [mbhr_pkg::HDR_KEEP];
   logic [KW-1:0] k_ff, k_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;

   logic          acc;
   logic [7:0]    rx;
   logic [16:0]   total_now;
   logic [7:0]    fn;
   logic [16:0]   addr2;
   logic [15:0]   qty;
   logic [16:0]   qty2;
   logic [7:0]    bc;
   logic          fn_bad, many_bad, rej_nx, frame_end, many_wr;
   logic          read_ok, wr1_ok, many_ok, respond;
   mbhr_pkg::kind_type kind_nx;
   logic [16:0]   addr2_q;
   logic [15:0]   qty_q;
   logic [KW-1:0] last_k;
   logic          out_free, data_byte;
   logic [15:0]   rsp_len;
   logic [7:0]    echo_byte;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata;

   mbhr_ram #(.WIDTH(8), .DEPTH(REG_BYTES)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rx  = req_bus.rx_byte;
   assign acc = req_bus.valid && req_bus.ready;

   always_comb begin
      hdr_nx = hdr_ff;
      if (pos_ff < 17'(mbhr_pkg::HDR_KEEP)) begin
         hdr_nx[pos_ff[3:0]] = rx;
      end
   end

   always_comb begin
      total_now = (pos_ff == 17'd5) ? ({1'b0, hdr_nx[4], hdr_nx[5]} + 17'(mbhr_pkg::MBAP_BYTES))
                                    : total_ff;
      fn    = hdr_nx[7];
      addr2 = {hdr_nx[8], hdr_nx[9], 1'b0};
      qty   = {hdr_nx[10], hdr_nx[11]};
      qty2  = {qty, 1'b0};
      bc    = hdr_nx[12];
      fn_bad = (fn != mbhr_pkg::FN_READ) && (fn != mbhr_pkg::FN_WRITE_ONE)
               && (fn != mbhr_pkg::FN_WRITE_MANY);
      many_bad = (qty == 16'd0) || (17'(bc) != qty2)
                 || (17'(mbhr_pkg::MIN_MANY) + 17'(bc) > total_now)
                 || (18'(addr2) + 18'(bc) > RB);
      rej_nx = rej_ff
               || (pos_ff == 17'd5 && total_now < 17'(mbhr_pkg::MIN_FRAME))
               || (pos_ff == 17'd7 && fn_bad)
               || (pos_ff == 17'd12 && fn == mbhr_pkg::FN_WRITE_MANY && many_bad);
      frame_end = (pos_ff >= 17'd5) && (18'(pos_ff) + 18'd1 >= 18'(total_now));
      many_wr = (pos_ff >= 17'(mbhr_pkg::HDR_KEEP)) && (fn == mbhr_pkg::FN_WRITE_MANY)
                && !rej_ff && (pos_ff - 17'(mbhr_pkg::HDR_KEEP) < 17'(bc));
      read_ok = (qty != 16'd0) && (qty <= 16'(MAX_READ_REGS))
                && (18'(addr2) + 18'(qty2) <= RB);
      wr1_ok  = 18'(addr2) + 18'd2 <= RB;
      many_ok = total_now >= 17'(mbhr_pkg::MIN_MANY);
      kind_nx = mbhr_pkg::KIND_WRITE_MANY;
      respond = 1'b0;
      if (!rej_nx) begin
         if (fn == mbhr_pkg::FN_READ) begin
            kind_nx = mbhr_pkg::KIND_READ;
            respond = read_ok;
         end else if (fn == mbhr_pkg::FN_WRITE_ONE) begin
            kind_nx = mbhr_pkg::KIND_WRITE_ONE;
            respond = wr1_ok;
         end else if (fn == mbhr_pkg::FN_WRITE_MANY) begin
            respond = many_ok;
         end
      end
   end

   always_comb begin
      addr2_q   = {hdr_ff[8], hdr_ff[9], 1'b0};
      qty_q     = {hdr_ff[10], hdr_ff[11]};
      last_k    = (kind_ff == mbhr_pkg::KIND_READ)
                  ? KW'(17'(mbhr_pkg::DATA_AT) - 17'd1 + {qty_q, 1'b0})
                  : KW'(mbhr_pkg::ECHO_LAST);
      out_free  = !out_valid_ff || rsp_bus.ready;
      data_byte = (kind_ff == mbhr_pkg::KIND_READ) && (k_ff >= KW'(mbhr_pkg::DATA_AT));
      rsp_len   = (kind_ff == mbhr_pkg::KIND_READ) ? (qty_q[14:0] * 2'd2 + 16'd3) : 16'd6;
      case (k_ff)
         KW'(0):  echo_byte = hdr_ff[0];
         KW'(1):  echo_byte = hdr_ff[1];
         KW'(2):  echo_byte = hdr_ff[2];
         KW'(3):  echo_byte = hdr_ff[3];
         KW'(4):  echo_byte = rsp_len[15:8];
         KW'(5):  echo_byte = rsp_len[7:0];
         KW'(6):  echo_byte = hdr_ff[6];
         KW'(7):  echo_byte = hdr_ff[7];
         KW'(8):  echo_byte = (kind_ff == mbhr_pkg::KIND_READ) ? {qty_q[6:0], 1'b0}
                                                               : hdr_ff[8];
         KW'(9):  echo_byte = hdr_ff[9];
         KW'(10): echo_byte = hdr_ff[10];
         default: echo_byte = hdr_ff[11];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbhr_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(REG_BYTES - 1)) begin
               state_in = mbhr_pkg::ST_RX;
            end
         end
         mbhr_pkg::ST_RX: begin
            if (acc && frame_end && respond) begin
               state_in = (kind_nx == mbhr_pkg::KIND_WRITE_ONE) ? mbhr_pkg::ST_WR_HI
                                                                : mbhr_pkg::ST_EMIT;
            end
         end
         mbhr_pkg::ST_WR_HI: state_in = mbhr_pkg::ST_WR_LO;
         mbhr_pkg::ST_WR_LO: state_in = mbhr_pkg::ST_EMIT;
         mbhr_pkg::ST_EMIT: begin
            if (out_free) begin
               if (data_byte) begin
                  state_in = mbhr_pkg::ST_FETCH;
               end else if (k_ff == last_k) begin
                  state_in = mbhr_pkg::ST_RX;
               end
            end
         end
         mbhr_pkg::ST_FETCH: begin
            state_in = (k_ff == last_k) ? mbhr_pkg::ST_RX : mbhr_pkg::ST_EMIT;
         end
         default: state_in = mbhr_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == mbhr_pkg::ST_RX);
      pos_in   = pos_ff;
      total_in = total_ff;
      rej_in   = rej_ff;
      kind_in  = kind_ff;
      k_in     = k_ff;
      clr_in   = clr_ff + AW'(1);
      mem_we    = 1'b0;
      mem_waddr = AW'(addr2 + (pos_ff - 17'(mbhr_pkg::HDR_KEEP)));
      mem_wdata = rx;
      mem_raddr = AW'(addr2_q + 17'(k_ff) - 17'(mbhr_pkg::DATA_AT));
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         mbhr_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
         end
         mbhr_pkg::ST_RX: begin
            if (acc) begin
               mem_we = many_wr;
               if (frame_end) begin
                  pos_in   = 17'd0;
                  total_in = 17'd0;
                  rej_in   = 1'b0;
                  kind_in  = kind_nx;
                  k_in     = KW'(0);
               end else begin
                  pos_in   = pos_ff + 17'd1;
                  total_in = total_now;
                  rej_in   = rej_nx;
               end
            end
         end
         mbhr_pkg::ST_WR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(addr2_q);
            mem_wdata = hdr_ff[10];
         end
         mbhr_pkg::ST_WR_LO: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(addr2_q) + AW'(1);
            mem_wdata = hdr_ff[11];
         end
         mbhr_pkg::ST_EMIT: begin
            if (out_free && !data_byte) begin
               out_valid_in = 1'b1;
               out_byte_in  = echo_byte;
               out_last_in  = (k_ff == last_k);
               k_in         = k_ff + KW'(1);
            end
         end
         mbhr_pkg::ST_FETCH: begin
            out_valid_in = 1'b1;
            out_byte_in  = mem_rdata;
            out_last_in  = (k_ff == last_k);
            k_in         = k_ff + KW'(1);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbhr_pkg::ST_CLEAR;
         pos_ff       <= '0;
         total_ff     <= '0;
         rej_ff       <= 1'b0;
         clr_ff       <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         rej_ff       <= rej_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      if (acc) begin
         hdr_ff <= hdr_nx;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.tx_byte = out_byte_ff;
   assign rsp_bus.last    = out_last_ff;
endmodule

>>> hw/rtl/mbhr_check.sv
module mbhr_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last
);
   // hold the word while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("response word changed while stalled");

   // no request word while a response is only partly sent
   a_no_rx_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a response");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_clear_pass: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready before the store is cleared");
endmodule

bind modbus_tcp_holding_register_slave mbhr_check u_mbhr_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_tx_byte (rsp_bus.tx_byte),
   .rsp_last    (rsp_bus.last)
);

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned NUM_REGS  = 256;
   localparam int unsigned READ_MAX  = 16;
   localparam int          CYCLE_CAP = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } reply_word_type;

   logic clock;
   logic reset;

   mbhr_req_if req_bus ();
   mbhr_rsp_if rsp_bus ();

   modbus_tcp_holding_register_slave #(
      .REG_BYTES(NUM_REGS),
      .MAX_READ_REGS(READ_MAX)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   logic [7:0]     pending_bytes[$];
   reply_word_type expected_reply[$];

   logic [16:0] frame_pos;
   logic [16:0] frame_len;
   logic [7:0]  hdr[mbhr_pkg::HDR_KEEP];
   logic        frame_drop;
   logic [7:0]  store[NUM_REGS];

   int  mismatches;
   int  cycles;
   bit  stimulus_done;
   bit  calm;

   function automatic int unsigned hdr_word(int at);
      return {hdr[at], hdr[at + 1]};
   endfunction

   function automatic void push_byte(logic [7:0] b, logic l);
      reply_word_type w;
      w.data = b;
      w.last = l;
      expected_reply.push_back(w);
   endfunction

   function automatic void push_prefix(int unsigned len);
      push_byte(hdr[0], 0);
      push_byte(hdr[1], 0);
      push_byte(hdr[2], 0);
      push_byte(hdr[3], 0);
      push_byte(len[15:8], 0);
      push_byte(len[7:0], 0);
      push_byte(hdr[6], 0);
      push_byte(hdr[7], 0);
   endfunction

   function automatic void close_frame();
      int unsigned addr2;
      int unsigned qty;
      logic [7:0]  fn;
      addr2 = hdr_word(8) * 2;
      qty   = hdr_word(10);
      fn    = hdr[7];
      if (frame_drop) return;
      if (fn == mbhr_pkg::FN_READ) begin
         if (qty == 0 || qty > READ_MAX || addr2 + qty * 2 > NUM_REGS) return;
         push_prefix(qty * 2 + 3);
         push_byte(8'(qty * 2), 0);
         for (int i = 0; i < qty * 2; i++)
            push_byte(store[addr2 + i], i == qty * 2 - 1);
      end else if (fn == mbhr_pkg::FN_WRITE_ONE || fn == mbhr_pkg::FN_WRITE_MANY) begin
         if (fn == mbhr_pkg::FN_WRITE_ONE) begin
            if (addr2 + 2 > NUM_REGS) return;
            store[addr2]     = hdr[10];
            store[addr2 + 1] = hdr[11];
         end else if (frame_len < mbhr_pkg::MIN_MANY) begin
            return;
         end
         push_prefix(6);
         push_byte(hdr[8], 0);
         push_byte(hdr[9], 0);
         push_byte(hdr[10], 0);
         push_byte(hdr[11], 1);
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b);
      int unsigned pos;
      int unsigned qty;
      int unsigned cnt;
      pos = frame_pos;
      if (pos < mbhr_pkg::HDR_KEEP) hdr[pos] = b;
      if (pos == 5) begin
         frame_len = 17'(hdr_word(4) + mbhr_pkg::MBAP_BYTES);
         if (frame_len < mbhr_pkg::MIN_FRAME) frame_drop = 1;
      end
      if (pos == 7 && hdr[7] != mbhr_pkg::FN_READ && hdr[7] != mbhr_pkg::FN_WRITE_ONE &&
          hdr[7] != mbhr_pkg::FN_WRITE_MANY)
         frame_drop = 1;
      if (pos == 12 && hdr[7] == mbhr_pkg::FN_WRITE_MANY) begin
         qty = hdr_word(10);
         cnt = hdr[12];
         if (qty == 0 || cnt != qty * 2 || 13 + cnt > frame_len ||
             hdr_word(8) * 2 + cnt > NUM_REGS)
            frame_drop = 1;
      end
      if (pos >= 13 && hdr[7] == mbhr_pkg::FN_WRITE_MANY && !frame_drop && pos - 13 < hdr[12])
         store[(hdr_word(8) * 2 + pos - 13) % NUM_REGS] = b;
      if (pos >= 5 && pos + 1 >= frame_len) begin
         close_frame();
         frame_pos  = 0;
         frame_len  = 0;
         frame_drop = 0;
      end else begin
         frame_pos = 17'(pos + 1);
      end
   endfunction

   task automatic queue_frame(logic [7:0] fn, int unsigned addr, int unsigned qty,
                              int extra, bit bad_count);
      logic [7:0]  body[$];
      int unsigned len;
      body.push_back(8'($urandom));
      body.push_back(fn);
      body.push_back(addr[15:8]);
      body.push_back(addr[7:0]);
      body.push_back(qty[15:8]);
      body.push_back(qty[7:0]);
      if (fn == mbhr_pkg::FN_WRITE_MANY) begin
         body.push_back(bad_count ? 8'($urandom) : 8'(qty * 2));
         for (int i = 0; i < qty * 2; i++) body.push_back(8'($urandom));
      end
      for (int i = 0; i < extra; i++) body.push_back(8'($urandom));
      len = body.size();
      pending_bytes.push_back(8'($urandom));
      pending_bytes.push_back(8'($urandom));
      pending_bytes.push_back(8'($urandom));
      pending_bytes.push_back(8'($urandom));
      pending_bytes.push_back(len[15:8]);
      pending_bytes.push_back(len[7:0]);
      foreach (body[i]) pending_bytes.push_back(body[i]);
   endtask

   task automatic queue_short(int unsigned len);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(len[15:8]);
      pending_bytes.push_back(len[7:0]);
      for (int i = 0; i < len; i++) pending_bytes.push_back(8'($urandom));
   endtask

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
   end

   initial begin
      frame_pos  = 0;
      frame_len  = 0;
      frame_drop = 0;
      foreach (hdr[i]) hdr[i] = 0;
      foreach (store[i]) store[i] = 0;

      queue_frame(mbhr_pkg::FN_READ, 0, 1, 0, 0);
      queue_frame(mbhr_pkg::FN_WRITE_ONE, 0, 16'hFFFF, 0, 0);
      queue_frame(mbhr_pkg::FN_WRITE_ONE, 127, 16'h00FF, 2, 0);
      queue_frame(mbhr_pkg::FN_WRITE_MANY, 0, 3, 0, 0);
      queue_frame(mbhr_pkg::FN_READ, 0, READ_MAX, 0, 0);
      queue_frame(mbhr_pkg::FN_READ, 127, 1, 1, 0);
      queue_frame(mbhr_pkg::FN_READ, 120, READ_MAX, 0, 0);
      queue_frame(mbhr_pkg::FN_READ, 0, 0, 0, 0);
      queue_frame(mbhr_pkg::FN_READ, 0, READ_MAX + 1, 0, 0);
      queue_frame(mbhr_pkg::FN_WRITE_ONE, 128, 5, 0, 0);
      queue_frame(mbhr_pkg::FN_WRITE_ONE, 16'hFFFF, 5, 0, 0);
      queue_frame(mbhr_pkg::FN_WRITE_MANY, 0, 0, 0, 0);
      queue_frame(mbhr_pkg::FN_WRITE_MANY, 2, 2, 0, 1);
      queue_frame(mbhr_pkg::FN_WRITE_MANY, 126, 4, 0, 0);
      queue_frame(8'h04, 0, 1, 0, 0);
      queue_frame(8'hFF, 0, 1, 0, 0);
      queue_short(5);
      queue_short(0);
      queue_frame(mbhr_pkg::FN_READ, 0, 4, 0, 0);

      while (pending_bytes.size() < 500) begin
         int sel;
         sel = $urandom_range(0, 99);
         if (sel < 35)
            queue_frame(mbhr_pkg::FN_READ, $urandom_range(0, 130), $urandom_range(1, READ_MAX),
                        $urandom_range(0, 1) ? 0 : $urandom_range(1, 3), 0);
         else if (sel < 60)
            queue_frame(mbhr_pkg::FN_WRITE_ONE, $urandom_range(0, 130), $urandom,
                        $urandom_range(0, 1), 0);
         else if (sel < 85)
            queue_frame(mbhr_pkg::FN_WRITE_MANY, $urandom_range(0, 130), $urandom_range(1, 8),
                        $urandom_range(0, 1), $urandom_range(0, 19) == 0);
         else if (sel < 90)
            queue_frame(8'($urandom), $urandom, $urandom, $urandom_range(0, 2), 0);
         else if (sel < 95)
            queue_frame(mbhr_pkg::FN_READ, $urandom, $urandom, 0, 0);
         else
            queue_short($urandom_range(0, 5));
      end
   end

   always @(posedge clock) begin
      cycles <= reset ? 0 : cycles + 1;
      calm   <= (cycles % 1500) >= 900;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'h00;
         rsp_bus.ready   <= 1'b0;
         stimulus_done   <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_byte(req_bus.rx_byte);
            void'(pending_bytes.pop_front());
         end
         if ((!req_bus.valid || req_bus.ready) ) begin
            if (pending_bytes.size() > 0 &&
                (calm || $urandom_range(0, 99) >= 9)) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= pending_bytes[0];
            end else begin
               req_bus.valid <= 1'b0;
            end
            if (pending_bytes.size() == 0) stimulus_done <= 1'b1;
         end
         rsp_bus.ready <= calm || $urandom_range(0, 99) >= 9;
      end
   end

   always @(posedge clock) begin
      reply_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reply.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: tx_byte %h last %b", rsp_bus.tx_byte, rsp_bus.last);
         end else begin
            want = expected_reply.pop_front();
            if (want.data !== rsp_bus.tx_byte || want.last !== rsp_bus.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: expected %h/%b got %h/%b",
                           want.data, want.last, rsp_bus.tx_byte, rsp_bus.last);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      wait (stimulus_done && !req_bus.valid && expected_reply.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_reply.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      wait (cycles >= CYCLE_CAP);
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mbhr_pkg.sv
hw/rtl/mbhr_if.sv
hw/rtl/mbhr_ram.sv
hw/rtl/modbus_tcp_holding_register_slave.sv
hw/rtl/mbhr_check.sv
bench/tb_top.sv
